// ===== rtl/core/simhash_near_duplicate_filter_top_assert.svh =====
// Assertion macros for the simhash near-duplicate filter.
`ifndef SIMHASH_NEAR_DUPLICATE_FILTER_TOP_ASSERT_SVH
`define SIMHASH_NEAR_DUPLICATE_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define SND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SND_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SND_ASSERT(lbl, prop, msg)
`define SND_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/snd_pkg.sv =====
// Shared types, constants and a function of the simhash near-duplicate filter.
`default_nettype none
package snd_pkg;

  localparam int FP_W            = 64;
  localparam int LIMIT_W         = 7;
  localparam int DIST_W          = 7;
  localparam int STORE_DEPTH_DEF = 256;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take the input transaction
    logic rd_en;   // read next stored hash
    logic commit;  // decide, update store, load result
  } snd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic last_idx;
    logic out_free;
  } snd_sts_t;

  // adder tree, six levels
  function automatic logic [DIST_W-1:0] popcount64(input logic [FP_W-1:0] v);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/simhash_near_duplicate_filter_top.sv =====
// Top level of the simhash near-duplicate filter.
`default_nettype none
`include "simhash_near_duplicate_filter_top_assert.svh"
// Each transaction carries a 64-bit simhash and a batch-start flag; the flag
// empties the hash store before the candidate is judged. The candidate is
// compared with every stored hash by the popcount of the XOR and is dropped
// (keep = 0) if any distance is below distance_limit, else kept and appended
// unless the same hash is already stored; with the store full, a new hash is
// kept, not stored, and store_overflow is set. The scan time of an item grows
// with N, the number of stored hashes, since the single read port of the
// store is scanned one entry per cycle; no new item is accepted until the last
// one is committed. A result waiting in the output register does not stop the
// next item from being accepted. No clearing pass after reset.
module simhash_near_duplicate_filter_top #(
  parameter int STORE_DEPTH = snd_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [63:0]                 in_tdata,   // [63:0] fingerprint
  input  wire logic                        in_tuser,   // [0] batch_start
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [7:0]                       out_tdata,  // [0] keep, [1] store_overflow
  input  wire logic                        cfg_we,
  input  wire logic [snd_pkg::LIMIT_W-1:0] cfg_wdata   // distance_limit
);

  snd_pkg::snd_cmd_t cmd;
  snd_pkg::snd_sts_t sts;
  logic              keep, ovf;

  snd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  snd_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_fp      (in_tdata),
    .in_start   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_keep   (keep),
    .out_ovf    (ovf)
  );

  assign out_tdata = {6'b0, ovf, keep};

  `SND_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "item accepted while busy")
  `SND_ASSERT(a_commit_free, cmd.commit |-> sts.out_free, "result overwrote pending result")
  `SND_ASSERT(a_commit_shows, cmd.commit |=> out_tvalid, "committed result not shown")
  `SND_ASSERT_ALWAYS(a_reset_quiet, $past(!rst_n) |-> !out_tvalid, "result valid after reset")

endmodule
`default_nettype wire

// ===== rtl/core/snd_datapath.sv =====
// Datapath: hash store, scan counter, distance compare and result register.
`default_nettype none
module snd_datapath #(
  parameter int STORE_DEPTH = snd_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire snd_pkg::snd_cmd_t            cmd,
  output snd_pkg::snd_sts_t                 sts,
  input  wire logic [snd_pkg::FP_W-1:0]     in_fp,
  input  wire logic                         in_start,
  input  wire logic                         cfg_we,
  input  wire logic [snd_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  wire logic                         out_tready,
  output logic                              out_tvalid,
  output logic                              out_keep,
  output logic                              out_ovf
);

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [snd_pkg::FP_W-1:0]    mem [STORE_DEPTH];
  logic [snd_pkg::FP_W-1:0]    fp_r, rd_data_r;
  logic [CW-1:0]               count_r, idx_r;
  logic [snd_pkg::LIMIT_W-1:0] limit_r;
  logic                        rd_vld_r, dup_r, pres_r;
  logic                        out_vld_r, keep_r, ovf_r;
  logic [snd_pkg::DIST_W-1:0]  ham_dist;
  logic                        full, append;

  assign ham_dist = snd_pkg::popcount64(fp_r ^ rd_data_r);
  assign full     = (count_r == CW'(STORE_DEPTH));
  assign append   = !dup_r && !pres_r && !full;

  // store: single read port used while scanning, write on commit
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
    if (cmd.commit && append) begin
      mem[count_r[AW-1:0]] <= fp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fp_r <= in_fp;
    end
    if (cmd.load) begin
      dup_r  <= 1'b0;
      pres_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (ham_dist < limit_r)  dup_r  <= 1'b1;
      if (rd_data_r == fp_r)   pres_r <= 1'b1;
    end
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.rd_en) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.commit) begin
      keep_r <= !dup_r;
      ovf_r  <= !dup_r && !pres_r && full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      limit_r   <= snd_pkg::LIMIT_RST;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.load && in_start) begin
        count_r <= '0;
      end else if (cmd.commit && append) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.commit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.last_idx   = (idx_r == count_r - CW'(1));
  assign sts.out_free   = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_keep   = keep_r;
  assign out_ovf    = ovf_r;

endmodule
`default_nettype wire

// ===== rtl/core/snd_ctrl.sv =====
// Controller: sequences accept, store scan, drain and decision.
`default_nettype none
module snd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire snd_pkg::snd_sts_t sts,
  output snd_pkg::snd_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        // count already reflects a batch start here
        state_nxt = sts.count_zero ? S_DECIDE : S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.last_idx) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last read data is compared in this cycle
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench of the simhash near-duplicate filter: directed table, store fill, random batches.
module testbench;

  localparam int FP_W           = snd_pkg::FP_W;
  localparam int LIMIT_W        = snd_pkg::LIMIT_W;
  localparam int STORE_DEPTH    = snd_pkg::STORE_DEPTH_DEF;
  localparam int ITEM_TARGET    = 2000;
  localparam int QUIET_TAIL     = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_CAP      = 100;
  localparam int NUM_ROWS       = 22;
  localparam logic [FP_W-1:0] ALL_ONES = {FP_W{1'b1}};
  localparam logic [FP_W-1:0] BEEF     = 64'hDEAD_BEEF_CAFE_F00D;

  typedef struct packed {
    logic keep;
    logic overflow;
  } verdict_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               start;
    logic [FP_W-1:0]    fp;
    logic               fixed;     // expected verdict typed in below
    logic               keep;
    logic               overflow;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [63:0]        in_tdata = '0;   // [63:0] fingerprint
  logic               in_tuser = 1'b0; // [0] batch_start
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;       // [0] keep, [1] store_overflow
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  // typed expectation that travels with the current input transaction
  logic due_fixed = 1'b0;
  logic due_keep = 1'b0;
  logic due_overflow = 1'b0;

  // predictor state
  logic [FP_W-1:0]    kept_fp [STORE_DEPTH];
  int unsigned        kept_total = 0;
  logic [LIMIT_W-1:0] dist_limit = snd_pkg::LIMIT_RST;

  verdict_t        verdicts_due [$];
  logic [FP_W-1:0] batch_fps [$];
  int unsigned     mismatch_count = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     items_sent = 0;
  int unsigned     stall_left = 0;
  bit              gaps_on = 1'b1;
  bit              stalls_on = 1'b1;
  bit              tail_quiet = 1'b0;

  row_t directed_rows [NUM_ROWS] = '{
    '{7'd5,  1'b0, 64'h0,                  1'b1, 1'b1, 1'b0}, // empty store after reset
    '{7'd5,  1'b0, ALL_ONES,               1'b1, 1'b1, 1'b0},
    '{7'd5,  1'b0, 64'h1,                  1'b1, 1'b0, 1'b0},
    '{7'd5,  1'b0, 64'hF,                  1'b1, 1'b0, 1'b0},
    '{7'd5,  1'b0, 64'h1F,                 1'b1, 1'b1, 1'b0}, // distance equals limit
    '{7'd5,  1'b0, 64'h1F,                 1'b1, 1'b0, 1'b0},
    '{7'd5,  1'b1, 64'h1,                  1'b1, 1'b1, 1'b0}, // batch start empties store
    '{7'd5,  1'b0, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0},
    '{7'd5,  1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0},
    '{7'd5,  1'b0, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0},
    '{7'd0,  1'b1, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1, 1'b0},
    '{7'd0,  1'b0, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1, 1'b0}, // exact repeat, not re-added
    '{7'd0,  1'b0, 64'h0,                  1'b1, 1'b1, 1'b0},
    '{7'd65, 1'b0, ALL_ONES,               1'b1, 1'b0, 1'b0},
    '{7'd65, 1'b1, ALL_ONES,               1'b1, 1'b1, 1'b0},
    '{7'd65, 1'b0, 64'h0,                  1'b1, 1'b0, 1'b0},
    '{7'd64, 1'b0, 64'h0,                  1'b1, 1'b1, 1'b0},
    '{7'd64, 1'b0, 64'h1,                  1'b1, 1'b0, 1'b0},
    '{7'd1,  1'b1, BEEF,                   1'b1, 1'b1, 1'b0},
    '{7'd1,  1'b0, BEEF ^ 64'h1,           1'b1, 1'b1, 1'b0},
    '{7'd1,  1'b0, BEEF,                   1'b1, 1'b0, 1'b0},
    '{7'd2,  1'b0, BEEF ^ 64'h2,           1'b0, 1'b0, 1'b0}
  };

  simhash_near_duplicate_filter_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Judges one candidate and updates the kept-hash store.
  function automatic verdict_t judge_candidate(logic [FP_W-1:0] fp, logic start);
    verdict_t v;
    bit       dup;
    bit       present;
    dup = 1'b0;
    present = 1'b0;
    if (start) kept_total = 0;
    for (int i = 0; i < kept_total; i++) begin
      if (kept_fp[i] == fp) present = 1'b1;
      if ($countones(kept_fp[i] ^ fp) < dist_limit) begin
        dup = 1'b1;
        break;
      end
    end
    v.keep = !dup;
    v.overflow = 1'b0;
    if (!dup && !present) begin
      if (kept_total < STORE_DEPTH) begin
        kept_fp[kept_total] = fp;
        kept_total++;
      end else begin
        v.overflow = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic logic [FP_W-1:0] fresh_fp();
    return {$urandom, $urandom};
  endfunction

  // Flips exactly k distinct bits of base.
  function automatic logic [FP_W-1:0] flip_bits(logic [FP_W-1:0] base, int unsigned k);
    logic [FP_W-1:0] mask;
    mask = '0;
    while ($countones(mask) < k) mask[$urandom_range(0, FP_W - 1)] = 1'b1;
    return base ^ mask;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at %0t: %s, expected %0h, got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Scoreboard: predicts on input transactions, checks output transactions.
  always @(posedge clk) begin : scoreboard
    verdict_t want;
    bit       moved;
    if (!rst_n) begin
      dist_limit = snd_pkg::LIMIT_RST;
      kept_total = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we) dist_limit = cfg_wdata;
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        want = judge_candidate(in_tdata, in_tuser);
        if (due_fixed) want = '{keep: due_keep, overflow: due_overflow};
        verdicts_due = {verdicts_due, want};
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (verdicts_due.size() == 0) begin
          report_mismatch("result with nothing due", 64'h0, {56'h0, out_tdata});
        end else begin
          want = verdicts_due.pop_front();
          if (out_tdata[0] !== want.keep)
            report_mismatch("keep", {63'h0, want.keep}, {63'h0, out_tdata[0]});
          if (out_tdata[1] !== want.overflow)
            report_mismatch("store_overflow", {63'h0, want.overflow}, {63'h0, out_tdata[1]});
          if (out_tdata[7:2] !== 6'h0)
            report_mismatch("tdata padding", 64'h0, {58'h0, out_tdata[7:2]});
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simhash_near_duplicate_filter_top regression: fail");
        $finish;
      end
    end
  end

  // Result side backpressure in random bursts.
  always @(negedge clk) begin
    if (stall_left != 0 && !tail_quiet) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (stalls_on && !tail_quiet && $urandom_range(0, 6) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(0, 17);
    end else begin
      out_tready = 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(logic start, logic [FP_W-1:0] fp, logic fixed, logic keep,
                           logic overflow);
    if (gaps_on && !tail_quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = fp;
    in_tuser = start;
    due_fixed = fixed;
    due_keep = keep;
    due_overflow = overflow;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (items_sent >= ITEM_TARGET - QUIET_TAIL) tail_quiet = 1'b1;
    @(negedge clk);
  endtask

  // Drains the block, then writes the threshold while it is idle.
  task automatic set_limit(logic [LIMIT_W-1:0] value);
    in_tvalid = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One batch: mostly near copies of earlier hashes, 0 to limit + 2 bits apart, or all fresh.
  task automatic run_batch(int unsigned len, bit open, bit fresh_only);
    logic [FP_W-1:0] fp;
    int unsigned     k;
    int unsigned     reach;
    if (open) batch_fps.delete();
    reach = (dist_limit + 2 > FP_W) ? FP_W : dist_limit + 2;
    for (int i = 0; i < len; i++) begin
      if (fresh_only || batch_fps.size() == 0) begin
        fp = fresh_fp();
      end else begin
        case ($urandom_range(0, 9))
          0: fp = $urandom_range(0, 1) ? ALL_ONES : '0;
          1, 2, 3: fp = fresh_fp();
          default: begin
            k = $urandom_range(0, reach);
            fp = flip_bits(batch_fps[$urandom_range(0, batch_fps.size() - 1)], k);
          end
        endcase
      end
      send_item(open && i == 0, fp, 1'b0, 1'b0, 1'b0);
      batch_fps = {batch_fps, fp};
    end
  endtask

  initial begin : stimulus
    int unsigned  long_left;
    int unsigned  batches;
    logic [LIMIT_W-1:0] lim;
    long_left = 3;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].limit != dist_limit) set_limit(directed_rows[r].limit);
      send_item(directed_rows[r].start, directed_rows[r].fp, directed_rows[r].fixed,
                directed_rows[r].keep, directed_rows[r].overflow);
    end

    // fill the store to capacity, then overflow it
    set_limit(7'd0);
    run_batch(STORE_DEPTH + 1, 1'b1, 1'b1);
    send_item(1'b0, batch_fps[3], 1'b1, 1'b1, 1'b0);  // exact repeat with a full store
    send_item(1'b0, fresh_fp(), 1'b1, 1'b1, 1'b1);
    set_limit(7'd3);
    repeat (3) send_item(1'b0, fresh_fp(), 1'b0, 1'b0, 1'b0);
    set_limit(7'd65);
    send_item(1'b0, fresh_fp(), 1'b1, 1'b0, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: lim = 7'd0;
        1: lim = 7'd64;
        2: lim = 7'd65;
        3: lim = LIMIT_W'($urandom_range(0, 65));
        default: lim = LIMIT_W'($urandom_range(1, 12));
      endcase
      set_limit(lim);
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      batches = $urandom_range(1, 6);
      repeat (batches) begin
        if (long_left != 0 && dist_limit <= 12 && $urandom_range(0, 30) == 0 &&
            items_sent + 300 < ITEM_TARGET - QUIET_TAIL) begin
          long_left--;
          run_batch(STORE_DEPTH + $urandom_range(1, 12), 1'b1, 1'b1);
        end else begin
          run_batch($urandom_range(1, 20), $urandom_range(0, 7) != 0, 1'b0);
        end
      end
    end

    in_tvalid = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (STORE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simhash_near_duplicate_filter_top regression: pass");
    end else begin
      $display("simhash_near_duplicate_filter_top regression: fail");
    end
    $finish;
  end

endmodule
